// File: sv/tmrq_pkg.sv
// Shared types and constants of the timer expiry queue.
// No dependencies; used by tmrq_cell, timer_expiry_queue_unit and tmrq_checker.
`default_nettype none

package tmrq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TICK_W      = 32;
   localparam int VAL_W       = 32;
   localparam int PERIOD_W    = 16;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [TICK_W-1:0] TICK_MAX  = {TICK_W{1'b1}};

   // result kinds
   localparam logic [1:0] KIND_EXPIRED   = 2'd0;
   localparam logic [1:0] KIND_TICK_DONE = 2'd1;
   localparam logic [1:0] KIND_ACCEPTED  = 2'd2;
   localparam logic [1:0] KIND_REJECTED  = 2'd3;

   // request operations
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_CREATE = 1'b1;

   // register indexes
   localparam logic CSR_TASK_TIMER_ID = 1'b0;
   localparam logic CSR_TASK_PERIOD   = 1'b1;

   // cell commands
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_POP    = 2'd2;

   typedef struct packed {
      logic [TICK_W-1:0]       deadline;
      logic signed [VAL_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic [1:0] op;
      entry_type  ent;
   } cell_cmd_type;

endpackage

`default_nettype wire

// File: sv/tmrq_cell.sv
// One slot of the sorted timer chain: holds one entry, shifts right on
// insert and left on pop. Depends on tmrq_pkg.
`default_nettype none

module tmrq_cell (
   input  wire logic                   clock,
   input  wire tmrq_pkg::cell_cmd_type cmd,
   input  wire tmrq_pkg::entry_type    left_ent,
   input  wire logic                   left_greater,
   input  wire tmrq_pkg::entry_type    right_ent,
   input  wire logic                   occupied,
   output tmrq_pkg::entry_type         ent,
   output logic                        greater
);

   tmrq_pkg::entry_type ent_ff;
   tmrq_pkg::entry_type ent_in;

   // new entry goes in front of this one (free slots count as later)
   assign greater = !occupied || (ent_ff.deadline > cmd.ent.deadline);
   assign ent     = ent_ff;

   always_comb begin
      ent_in = ent_ff;
      unique case (cmd.op)
         tmrq_pkg::CELL_INSERT: begin
            if (left_greater) begin
               ent_in = left_ent;
            end else if (greater) begin
               ent_in = cmd.ent;
            end
         end
         tmrq_pkg::CELL_POP: begin
            ent_in = right_ent;
         end
         default: begin
            ent_in = ent_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

`default_nettype wire

// File: sv/timer_expiry_queue_unit.sv
// Timer expiry queue top level: request sequencer, tick counter and a
// chain of tmrq_cell slots kept sorted by deadline. Depends on tmrq_pkg.
//
// Usage:
//  - req_* carries one item: a tick (operation 0) or a create (operation 1
//    with deadline and tag_value). An item is taken when req_valid is high
//    and req_stall low; req_stall is high while an item is being worked.
//  - rsp_* returns results through one output register; the receiver holds
//    it with rsp_stall. Steps that load a result wait for that register to
//    free up; task timer pops and re-arm inserts go on meanwhile.
//  - csr_* writes task_timer_id (index 0) or task_period (index 1); always
//    ready, to be used only while the block is idle.
//  - Create: inserted into the chain in the accept cycle unless the queue is full
//    (rejected); the result waits for a free output register, then a new item is taken.
//  - Tick: the tick counter advances (saturating), then one head entry is
//    checked per cycle: expired entries leave one per cycle (a message each,
//    held back while the output register is not free, or counted for re-arm
//    when it is the task timer), each re-armed task timer is put back at one
//    insert per cycle, and a status result closes the run.
//  - Reset: queue empty, tick 0, task_timer_id 1, task_period 10, no result.
`default_nettype none

module timer_expiry_queue_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_operation,
   input  wire logic [tmrq_pkg::TICK_W-1:0]          req_deadline,
   input  wire logic signed [tmrq_pkg::VAL_W-1:0]    req_tag_value,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_kind,
   output logic [tmrq_pkg::TICK_W-1:0]               rsp_expired_deadline,
   output logic signed [tmrq_pkg::VAL_W-1:0]         rsp_expired_value,
   output logic                                      rsp_task_expired,
   output logic                                      rsp_last,
   // configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic                                 csr_index,
   input  wire logic [31:0]                          csr_wdata
);

   localparam int N = tmrq_pkg::QUEUE_DEPTH;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RESULT = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_REARM  = 3'd3;
   localparam logic [2:0] ST_STATUS = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [tmrq_pkg::CNT_W-1:0] count_ff, count_in;
   logic [tmrq_pkg::CNT_W-1:0] rearm_cnt_ff, rearm_cnt_in;
   logic [tmrq_pkg::TICK_W-1:0] now_ff, now_in;
   logic flag_ff, flag_in;
   logic [1:0] pend_kind_ff, pend_kind_in;
   logic signed [tmrq_pkg::VAL_W-1:0] task_id_ff, task_id_in;
   logic [tmrq_pkg::PERIOD_W-1:0] period_ff, period_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [tmrq_pkg::TICK_W-1:0] rsp_dl_ff, rsp_dl_in;
   logic signed [tmrq_pkg::VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic rsp_flag_ff, rsp_flag_in;
   logic rsp_last_ff, rsp_last_in;

   tmrq_pkg::cell_cmd_type cmd;
   tmrq_pkg::entry_type ent_w [N];
   logic grt_w [N];

   logic accept;
   logic out_free;
   logic head_expired;
   logic head_is_task;
   logic [tmrq_pkg::TICK_W:0] rearm_sum;
   logic [tmrq_pkg::TICK_W-1:0] rearm_dl;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign head_expired = (count_ff != '0) && (ent_w[0].deadline <= now_ff);
   assign head_is_task = (ent_w[0].value == task_id_ff);

   // re-arm deadline, saturating at the top of the tick range
   assign rearm_sum = {1'b0, now_ff} + {{(tmrq_pkg::TICK_W + 1 - tmrq_pkg::PERIOD_W){1'b0}},
                                        period_ff};
   assign rearm_dl  = rearm_sum[tmrq_pkg::TICK_W] ? tmrq_pkg::TICK_MAX
                                                   : rearm_sum[tmrq_pkg::TICK_W-1:0];

   // cell chain
   for (genvar i = 0; i < N; i++) begin : g_cell
      tmrq_cell u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .left_ent     (ent_w[(i == 0) ? 0 : i - 1]),
         .left_greater ((i == 0) ? 1'b0 : grt_w[(i == 0) ? 0 : i - 1]),
         .right_ent    (ent_w[(i == N - 1) ? N - 1 : i + 1]),
         .occupied     (count_ff > (tmrq_pkg::CNT_W)'(i)),
         .ent          (ent_w[i]),
         .greater      (grt_w[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rearm_cnt_in = rearm_cnt_ff;
      now_in       = now_ff;
      flag_in      = flag_ff;
      pend_kind_in = pend_kind_ff;
      task_id_in   = task_id_ff;
      period_in    = period_ff;

      cmd.op        = tmrq_pkg::CELL_HOLD;
      cmd.ent       = '{deadline: req_deadline, value: req_tag_value};

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dl_in    = rsp_dl_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tmrq_pkg::CSR_TASK_TIMER_ID: task_id_in = csr_wdata;
            tmrq_pkg::CSR_TASK_PERIOD:   period_in  = csr_wdata[tmrq_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == tmrq_pkg::OP_CREATE) begin
                  if (count_ff == tmrq_pkg::FULL_COUNT) begin
                     pend_kind_in = tmrq_pkg::KIND_REJECTED;
                  end else begin
                     pend_kind_in = tmrq_pkg::KIND_ACCEPTED;
                     cmd.op       = tmrq_pkg::CELL_INSERT;
                     count_in     = count_ff + 1'b1;
                  end
                  state_in = ST_RESULT;
               end else begin
                  if (now_ff != tmrq_pkg::TICK_MAX) begin
                     now_in = now_ff + 1'b1;
                  end
                  flag_in      = 1'b0;
                  rearm_cnt_in = '0;
                  state_in     = ST_DRAIN;
               end
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_dl_in    = '0;
               rsp_val_in   = '0;
               rsp_flag_in  = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (head_expired) begin
               if (head_is_task) begin
                  // task timer: leaves now, comes back after the pass
                  cmd.op       = tmrq_pkg::CELL_POP;
                  count_in     = count_ff - 1'b1;
                  rearm_cnt_in = rearm_cnt_ff + 1'b1;
                  flag_in      = 1'b1;
               end else if (out_free) begin
                  cmd.op       = tmrq_pkg::CELL_POP;
                  count_in     = count_ff - 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = tmrq_pkg::KIND_EXPIRED;
                  rsp_dl_in    = ent_w[0].deadline;
                  rsp_val_in   = ent_w[0].value;
                  rsp_flag_in  = 1'b0;
                  rsp_last_in  = 1'b0;
               end
            end else if (rearm_cnt_ff != '0) begin
               state_in = ST_REARM;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_REARM: begin
            // all re-armed entries are identical, so only their number matters
            cmd.op       = tmrq_pkg::CELL_INSERT;
            cmd.ent      = '{deadline: rearm_dl, value: task_id_ff};
            count_in     = count_ff + 1'b1;
            rearm_cnt_in = rearm_cnt_ff - 1'b1;
            if (rearm_cnt_ff == (tmrq_pkg::CNT_W)'(1)) begin
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = tmrq_pkg::KIND_TICK_DONE;
               rsp_dl_in    = '0;
               rsp_val_in   = '0;
               rsp_flag_in  = flag_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rearm_cnt_ff <= '0;
         now_ff       <= '0;
         flag_ff      <= 1'b0;
         task_id_ff   <= 32'sd1;
         period_ff    <= 16'd10;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rearm_cnt_ff <= rearm_cnt_in;
         now_ff       <= now_in;
         flag_ff      <= flag_in;
         task_id_ff   <= task_id_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dl_ff    <= rsp_dl_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_expired_deadline = rsp_dl_ff;
   assign rsp_expired_value    = rsp_val_ff;
   assign rsp_task_expired     = rsp_flag_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

`default_nettype wire

// File: sv/tmrq_checker.sv
// Port-level checks of timer_expiry_queue_unit, bound to the top level.
// Depends on tmrq_pkg.
`default_nettype none

module tmrq_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic [1:0]                           rsp_kind,
   input wire logic [tmrq_pkg::TICK_W-1:0]          rsp_expired_deadline,
   input wire logic                                 rsp_task_expired,
   input wire logic                                 rsp_last
);

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_kind) && $stable(rsp_expired_deadline))
      else $error("stalled result changed");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new item taken while one is in work");

   // only expiry messages are non-final
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != tmrq_pkg::KIND_EXPIRED)))
      else $error("last flag does not match result kind");

   a_flag_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_task_expired |-> rsp_kind == tmrq_pkg::KIND_TICK_DONE)
      else $error("task flag on a result other than tick done");

endmodule

bind timer_expiry_queue_unit tmrq_checker u_tmrq_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_kind             (rsp_kind),
   .rsp_expired_deadline (rsp_expired_deadline),
   .rsp_task_expired     (rsp_task_expired),
   .rsp_last             (rsp_last)
);

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench of timer_expiry_queue_unit: a scoreboard class
// predicts every result item; plain tasks drive requests and register writes.
// Depends on tmrq_pkg and the timer_expiry_queue_unit RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // One result item as the block presents it
   typedef struct {
      logic [1:0]                  kind;
      logic [tmrq_pkg::TICK_W-1:0] dl;
      logic [tmrq_pkg::VAL_W-1:0]  val;
      logic                        flag;
      logic                        last;
   } timer_result_type;

   // Scoreboard: own copy of the timer list, tick counter and registers
   class expiry_scoreboard_type;
      tmrq_pkg::entry_type               armed[$];
      timer_result_type                  awaited[$];
      logic [tmrq_pkg::TICK_W-1:0]       now_tick;
      logic signed [tmrq_pkg::VAL_W-1:0] task_id;
      logic [tmrq_pkg::PERIOD_W-1:0]     period;
      int                                errors;

      function new();
         now_tick = '0;
         task_id  = 32'sd1;
         period   = 16'd10;
         errors   = 0;
      endfunction

      function void write_reg(logic idx, logic [31:0] data);
         if (idx == tmrq_pkg::CSR_TASK_TIMER_ID) begin
            task_id = data;
         end else begin
            period = data[tmrq_pkg::PERIOD_W-1:0];
         end
      endfunction

      // stable sorted insert: behind every entry with a deadline not later
      function void arm(logic [tmrq_pkg::TICK_W-1:0] dl,
                        logic signed [tmrq_pkg::VAL_W-1:0] val);
         int                  pos;
         tmrq_pkg::entry_type e;
         pos = 0;
         while (pos < armed.size() && armed[pos].deadline <= dl) pos++;
         e.deadline = dl;
         e.value    = val;
         armed.insert(pos, e);
      endfunction

      function void push_result(logic [1:0] kind, logic [tmrq_pkg::TICK_W-1:0] dl,
                                logic [tmrq_pkg::VAL_W-1:0] val, logic flag, logic last);
         timer_result_type r;
         r.kind = kind;
         r.dl   = dl;
         r.val  = val;
         r.flag = flag;
         r.last = last;
         awaited.push_back(r);
      endfunction

      function void note_accepted(logic op, logic [tmrq_pkg::TICK_W-1:0] dl,
                                  logic signed [tmrq_pkg::VAL_W-1:0] val);
         int                          rearm;
         logic                        fired;
         logic [tmrq_pkg::TICK_W:0]   sum;
         logic [tmrq_pkg::TICK_W-1:0] rearm_dl;
         tmrq_pkg::entry_type         head;
         if (op == tmrq_pkg::OP_CREATE) begin
            if (armed.size() >= tmrq_pkg::QUEUE_DEPTH) begin
               push_result(tmrq_pkg::KIND_REJECTED, '0, '0, 1'b0, 1'b1);
            end else begin
               arm(dl, val);
               push_result(tmrq_pkg::KIND_ACCEPTED, '0, '0, 1'b0, 1'b1);
            end
            return;
         end
         if (now_tick != tmrq_pkg::TICK_MAX) now_tick++;
         fired = 1'b0;
         rearm = 0;
         while (armed.size() > 0 && armed[0].deadline <= now_tick) begin
            head = armed.pop_front();
            if (head.value == task_id) begin
               fired = 1'b1;
               rearm++;
            end else begin
               push_result(tmrq_pkg::KIND_EXPIRED, head.deadline, head.value, 1'b0, 1'b0);
            end
         end
         // re-armed task timers go back only after the removal pass
         sum      = {1'b0, now_tick} + period;
         rearm_dl = sum[tmrq_pkg::TICK_W] ? tmrq_pkg::TICK_MAX : sum[tmrq_pkg::TICK_W-1:0];
         repeat (rearm) arm(rearm_dl, task_id);
         push_result(tmrq_pkg::KIND_TICK_DONE, '0, '0, fired, 1'b1);
      endfunction

      function void match_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(timer_result_type got);
         timer_result_type want;
         if (awaited.size() == 0) begin
            $error("result kind %0d with nothing expected", got.kind);
            errors++;
            return;
         end
         want = awaited.pop_front();
         match_field("kind", want.kind, got.kind);
         match_field("expired_deadline", want.dl, got.dl);
         match_field("expired_value", want.val, got.val);
         match_field("task_expired", want.flag, got.flag);
         match_field("last", want.last, got.last);
      endfunction
   endclass

   // DUT signals; the inputs are driven to known values from time zero
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_operation = tmrq_pkg::OP_TICK;
   logic [tmrq_pkg::TICK_W-1:0]        req_deadline = '0;
   logic signed [tmrq_pkg::VAL_W-1:0]  req_tag_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [1:0]                         rsp_kind;
   logic [tmrq_pkg::TICK_W-1:0]        rsp_expired_deadline;
   logic signed [tmrq_pkg::VAL_W-1:0]  rsp_expired_value;
   logic                               rsp_task_expired;
   logic                               rsp_last;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic                               csr_index = tmrq_pkg::CSR_TASK_TIMER_ID;
   logic [31:0]                        csr_wdata = '0;

   expiry_scoreboard_type sb = new();

   int idle_pct  = 0;   // sender: chance per cycle of leaving valid low
   int stall_pct = 0;   // receiver: chance per cycle of stalling
   int hold_left = 0;   // long receiver hold-off, counted down per cycle

   timer_expiry_queue_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_deadline         (req_deadline),
      .req_tag_value        (req_tag_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_expired_deadline (rsp_expired_deadline),
      .rsp_expired_value    (rsp_expired_value),
      .rsp_task_expired     (rsp_task_expired),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   // Hard limit on run length; far above the slowest legal run
   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // Result side: check each accepted item at the edge, then pick the
   // stall for the next cycle. A pending hold-off wins over random stalls.
   always @(posedge clock) begin
      timer_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_kind;
         got.dl   = rsp_expired_deadline;
         got.val  = rsp_expired_value;
         got.flag = rsp_task_expired;
         got.last = rsp_last;
         sb.check_result(got);
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Offer one request item and wait for it to be taken. An optional idle
   // gap comes first, so valid is never lowered and raised in one step.
   task automatic send_item(logic op, logic [tmrq_pkg::TICK_W-1:0] dl,
                            logic [tmrq_pkg::VAL_W-1:0] val);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_deadline  <= dl;
      req_tag_value <= val;
      do @(posedge clock); while (req_stall);
      sb.note_accepted(op, dl, val);
   endtask

   // Tick with don't-care payload (still random so every bit toggles)
   task automatic send_tick();
      send_item(tmrq_pkg::OP_TICK, $urandom, $urandom);
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() > 0) @(posedge clock);
   endtask

   // Register write; only called with the block idle
   task automatic write_csr(logic idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Tag picker: mostly random, sometimes the task timer or an extreme
   function automatic logic [tmrq_pkg::VAL_W-1:0] pick_tag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return sb.task_id;
      if (r < 13) return 32'h8000_0000;
      if (r < 16) return 32'h7FFF_FFFF;
      return $urandom;
   endfunction

   // Random traffic. Deadlines sit mostly just ahead of the tick counter so
   // timers really expire; bursts of creates with shared deadlines fill the
   // queue (rejects) and give long expiry runs with equal deadlines.
   task automatic run_phase(int count, bit pause_midway);
      int                          burst_left;
      int                          r;
      logic [tmrq_pkg::TICK_W-1:0] burst_dl;
      logic [tmrq_pkg::TICK_W-1:0] dl;
      burst_left = 0;
      burst_dl   = '0;
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) drain();
         if (burst_left == 0 && $urandom_range(0, 99) < 4) begin
            burst_left = $urandom_range(20, 36);
            burst_dl   = sb.now_tick + $urandom_range(1, 3);
         end
         if (burst_left > 0) begin
            burst_left--;
            send_item(tmrq_pkg::OP_CREATE, burst_dl + $urandom_range(0, 1), pick_tag());
         end else if ($urandom_range(0, 99) < 45) begin
            send_tick();
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70)      dl = sb.now_tick + $urandom_range(0, 6);
            else if (r < 85) dl = $urandom_range(0, sb.now_tick);   // already due
            else if (r < 98) dl = sb.now_tick + $urandom_range(0, 30);
            else             dl = $urandom;                         // mostly never due
            send_item(tmrq_pkg::OP_CREATE, dl, pick_tag());
         end
      end
   endtask

   initial begin
      logic [31:0] id_val;
      logic [31:0] period_val;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // --- directed, reset register values (task id 1, period 10) ---
      send_tick();                                            // empty queue: status only
      send_item(tmrq_pkg::OP_CREATE, 32'd0, 32'h8000_0000);   // already due, min tag
      send_item(tmrq_pkg::OP_CREATE, 32'd1, 32'h7FFF_FFFF);   // max tag
      send_item(tmrq_pkg::OP_CREATE, 32'd1, 32'd1);           // task timer
      send_item(tmrq_pkg::OP_CREATE, 32'd1, 32'd0);           // equal deadline, after it
      send_item(tmrq_pkg::OP_CREATE, 32'd2, 32'd1);           // second task timer
      send_item(tmrq_pkg::OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // never due
      send_tick();                                            // tick 2: five leave in order
      send_tick();                                            // tick 3: nothing due, status only
      send_item(tmrq_pkg::OP_CREATE, 32'd3, 32'd5);
      send_item(tmrq_pkg::OP_CREATE, 32'd3, 32'd6);
      // ticks up to 13: both re-armed task timers come due again
      repeat (10) send_tick();

      // --- random phases, one register setting each ---
      for (int p = 0; p < 6; p++) begin
         drain();
         case (p)
            0: begin id_val = 32'h8000_0000; period_val = 32'd1; end
            1: begin id_val = 32'h7FFF_FFFF; period_val = 32'h0000_FFFF; end
            2: begin id_val = 32'd0;         period_val = 32'hABCD_0000; end // period 0
            3: begin id_val = $urandom;      period_val = $urandom_range(2, 12); end
            4: begin id_val = 32'hFFFF_FFFF; period_val = 32'({$urandom, 16'd3} >> 16); end
            default: begin id_val = $urandom; period_val = $urandom; end
         endcase
         write_csr(tmrq_pkg::CSR_TASK_TIMER_ID, id_val);
         write_csr(tmrq_pkg::CSR_TASK_PERIOD, period_val);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         // receiver holds off while requests keep coming: input backs up
         if (p == 1) hold_left = 400;
         run_phase(73, p == 3);
      end

      drain();
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// File: timer_expiry_queue_unit.f
sv/tmrq_pkg.sv
sv/tmrq_cell.sv
sv/timer_expiry_queue_unit.sv
sv/tmrq_checker.sv
sim/tb_top.sv
